FILE: hw/rtl/tpc_pkg.sv
// Shared types and constants of the triangle plane clipper.
package tpc_pkg;

	// Coordinate width and the widths of the distance and edge arithmetic.
	localparam int CW            = 32;
	localparam int DW            = 50;
	localparam int DMW           = 49;
	localparam int DENW          = 51;
	localparam int MAGW          = 33;
	localparam int DM_LO_W       = 25;
	localparam int NUMW          = 82;
	localparam int QW            = 33;
	localparam int DIV_PER_STAGE = 3;
	localparam int DIV_STAGES    = QW / DIV_PER_STAGE;
	localparam int EDGE_LAT      = DIV_STAGES + 3;
	localparam int TRI_BITS      = 9 * CW;

	// Configuration register indexes.
	localparam logic [1:0] REG_COEF_X     = 2'd0;
	localparam logic [1:0] REG_COEF_Y     = 2'd1;
	localparam logic [1:0] REG_COEF_Z     = 2'd2;
	localparam logic [1:0] REG_COEF_CONST = 2'd3;

	typedef logic signed [CW-1:0] coord_t;
	typedef coord_t [2:0] vtx_t;
	typedef vtx_t [2:0] tri_t;

	typedef enum logic [1:0] {
		KIND_WHOLE = 2'd0,
		KIND_ONE   = 2'd1,
		KIND_TWO   = 2'd2,
		KIND_DROP  = 2'd3
	} clip_kind_t;

	// One axis of one edge intersection: moving vertex coordinate, offset
	// magnitude and direction, moving distance and divisor.
	typedef struct packed {
		logic             sub;
		coord_t           vm;
		logic [MAGW-1:0]  mag;
		logic [DMW-1:0]   dm;
		logic [DENW-1:0]  den;
	} edge_job_t;

	// What the output stage needs besides the intersection points.
	typedef struct packed {
		tri_t       v;
		clip_kind_t kind;
		logic [1:0] pos;
		logic [1:0] third;
	} side_t;

endpackage

FILE: hw/rtl/tpc_dist.sv
// Two-stage plane distance of one vertex.
module tpc_dist (
	input  logic                   clk,
	input  logic                   en,
	input  tpc_pkg::coord_t        coef_x,
	input  tpc_pkg::coord_t        coef_y,
	input  tpc_pkg::coord_t        coef_z,
	input  tpc_pkg::coord_t        coef_const,
	input  tpc_pkg::vtx_t          vtx,
	output logic signed [tpc_pkg::DW-1:0] plane_d
);

	logic signed [2*tpc_pkg::CW-1:0] prod_s1 [3];
	tpc_pkg::coord_t                 cc_s1;
	logic signed [tpc_pkg::DW-1:0]   dist_s2;
	logic signed [tpc_pkg::DW-1:0]   sum;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0] <= $signed(coef_x) * $signed(vtx[0]);
			prod_s1[1] <= $signed(coef_y) * $signed(vtx[1]);
			prod_s1[2] <= $signed(coef_z) * $signed(vtx[2]);
			cc_s1      <= coef_const;
		end
	end

	// Each product is floored to Q.16 by dropping its low sixteen bits.
	always_comb begin
		sum = tpc_pkg::DW'($signed(prod_s1[0][2*tpc_pkg::CW-1:16]))
		    + tpc_pkg::DW'($signed(prod_s1[1][2*tpc_pkg::CW-1:16]))
		    + tpc_pkg::DW'($signed(prod_s1[2][2*tpc_pkg::CW-1:16]))
		    + tpc_pkg::DW'($signed(cc_s1));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s2 <= sum;
		end
	end

	assign plane_d = dist_s2;

endmodule

FILE: hw/rtl/tpc_edge.sv
// Pipelined edge intersection of one axis: split multiply, restoring divide, saturation.
module tpc_edge #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 en,
	input  tpc_pkg::edge_job_t   job,
	output tpc_pkg::coord_t      res
);

	localparam int SAT_W = (COORD_WIDTH < tpc_pkg::CW) ? COORD_WIDTH : tpc_pkg::CW;
	localparam int RW    = tpc_pkg::QW + 2;
	localparam int PLW   = tpc_pkg::MAGW + tpc_pkg::DM_LO_W;
	localparam int PHW   = tpc_pkg::MAGW + tpc_pkg::DMW - tpc_pkg::DM_LO_W;
	localparam logic signed [RW-1:0] SAT_HI =
		$signed(RW'(1) << (SAT_W - 1)) - $signed(RW'(1));
	localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - $signed(RW'(1));

	logic [PLW-1:0]              pl_s1;
	logic [PHW-1:0]              ph_s1;
	logic                        sub_s1, sub_s2;
	tpc_pkg::coord_t             vm_s1, vm_s2;
	logic [tpc_pkg::DENW-1:0]    den_s1, den_s2;
	logic [tpc_pkg::NUMW-1:0]    num_s2;

	logic [tpc_pkg::DENW-1:0]    div_rem_s [tpc_pkg::DIV_STAGES];
	logic [tpc_pkg::QW-1:0]      div_lq_s  [tpc_pkg::DIV_STAGES];
	logic [tpc_pkg::DENW-1:0]    div_den_s [tpc_pkg::DIV_STAGES];
	logic                        div_sub_s [tpc_pkg::DIV_STAGES];
	tpc_pkg::coord_t             div_vm_s  [tpc_pkg::DIV_STAGES];

	logic signed [RW-1:0]        sum;
	tpc_pkg::coord_t             res_s;

	// Distance is split in two so that each partial product fits in 58 bits.
	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1  <= PLW'(job.mag) * PLW'(job.dm[tpc_pkg::DM_LO_W-1:0]);
			ph_s1  <= PHW'(job.mag) * PHW'(job.dm[tpc_pkg::DMW-1:tpc_pkg::DM_LO_W]);
			sub_s1 <= job.sub;
			vm_s1  <= job.vm;
			den_s1 <= job.den;
			num_s2 <= tpc_pkg::NUMW'(pl_s1)
			        + (tpc_pkg::NUMW'(ph_s1) << tpc_pkg::DM_LO_W);
			sub_s2 <= sub_s1;
			vm_s2  <= vm_s1;
			den_s2 <= den_s1;
		end
	end

	// The quotient never exceeds the offset magnitude, so the numerator bits
	// above the quotient width already form a remainder below the divisor.
	for (genvar g = 0; g < tpc_pkg::DIV_STAGES; g++) begin : g_div
		logic [tpc_pkg::DENW-1:0] rem_in, rem_out, den_in;
		logic [tpc_pkg::QW-1:0]   lq_in, lq_out;
		logic                     sub_in;
		tpc_pkg::coord_t          vm_in;
		logic [tpc_pkg::DENW:0]   trial;

		if (g == 0) begin : g_first
			assign rem_in = tpc_pkg::DENW'(num_s2[tpc_pkg::NUMW-1:tpc_pkg::QW]);
			assign lq_in  = num_s2[tpc_pkg::QW-1:0];
			assign den_in = den_s2;
			assign sub_in = sub_s2;
			assign vm_in  = vm_s2;
		end else begin : g_next
			assign rem_in = div_rem_s[g-1];
			assign lq_in  = div_lq_s[g-1];
			assign den_in = div_den_s[g-1];
			assign sub_in = div_sub_s[g-1];
			assign vm_in  = div_vm_s[g-1];
		end

		always_comb begin
			rem_out = rem_in;
			lq_out  = lq_in;
			trial   = '0;
			for (int k = 0; k < tpc_pkg::DIV_PER_STAGE; k++) begin
				trial  = {rem_out, lq_out[tpc_pkg::QW-1]};
				lq_out = {lq_out[tpc_pkg::QW-2:0], 1'b0};
				if (trial >= {1'b0, den_in}) begin
					trial     = trial - {1'b0, den_in};
					lq_out[0] = 1'b1;
				end
				rem_out = trial[tpc_pkg::DENW-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_rem_s[g] <= rem_out;
				div_lq_s[g]  <= lq_out;
				div_den_s[g] <= den_in;
				div_sub_s[g] <= sub_in;
				div_vm_s[g]  <= vm_in;
			end
		end
	end

	always_comb begin
		if (div_sub_s[tpc_pkg::DIV_STAGES-1]) begin
			sum = RW'($signed(div_vm_s[tpc_pkg::DIV_STAGES-1]))
			    - $signed(RW'(div_lq_s[tpc_pkg::DIV_STAGES-1]));
		end else begin
			sum = RW'($signed(div_vm_s[tpc_pkg::DIV_STAGES-1]))
			    + $signed(RW'(div_lq_s[tpc_pkg::DIV_STAGES-1]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sum > SAT_HI) begin
				res_s <= SAT_HI[tpc_pkg::CW-1:0];
			end else if (sum < SAT_LO) begin
				res_s <= SAT_LO[tpc_pkg::CW-1:0];
			end else begin
				res_s <= sum[tpc_pkg::CW-1:0];
			end
		end
	end

	assign res = res_s;

endmodule

FILE: hw/rtl/triangle_plane_clipper.sv
// Top level of the triangle plane clipper: distance, classification, edge lanes, output.
//
// Usage: each beat on the s_ channel carries one triangle (nine signed Q16.16
// coordinates, vertex zero first, x lowest). The block keeps the side of the
// plane coef_x*x + coef_y*y + coef_z*z + coef_const where the distance is not
// positive. A triangle fully on the kept side leaves as one beat with tuser 0,
// one fully outside yields no beat, one cut with a single kept vertex region
// yields one beat with tuser 1, and one that leaves a quadrilateral yields two
// beats with tuser 2. tlast marks the final beat produced for an input.
// Coefficients are written through cfg_we, cfg_addr and cfg_wdata; the user
// must write them only while the block is idle, which the block itself does not
// enforce. Reset clears them to zero and empties the pipeline.
// Pipeline: an accepted input beat passes two distance stages, one classify
// stage, edge stages made of two multiply stages, eleven three-bit-per-stage
// restoring division stages, one saturation stage, then one output register.
// Throughput: one input beat per cycle while outputs are single beats and
// m_tready is high; an input that splits in two holds the pipeline while its
// first beat is presented. When m_tready is low while a result is presented,
// the whole pipeline freezes with its data held, and s_tready drops with it.
module triangle_plane_clipper #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port.
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_addr,
	input  logic [tpc_pkg::CW-1:0]        cfg_wdata,
	// Input triangles.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z, in_c_x, in_c_y, in_c_z
	input  logic [tpc_pkg::TRI_BITS-1:0]  s_tdata,
	// Result triangles.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z, out_c_x, out_c_y, out_c_z
	output logic [tpc_pkg::TRI_BITS-1:0]  m_tdata,
	// clip_case
	output logic [1:0]                    m_tuser,
	output logic                          m_tlast
);

	tpc_pkg::coord_t coef_x_q, coef_y_q, coef_z_q, coef_const_q;

	logic            en;
	logic            vld_s1, vld_s2, vld_s3;
	tpc_pkg::tri_t   v_s1, v_s2;
	logic signed [tpc_pkg::DW-1:0] vd [3];

	tpc_pkg::edge_job_t job_s3 [2][3];
	tpc_pkg::side_t     side_s3;
	tpc_pkg::side_t     side_c;
	tpc_pkg::edge_job_t job_c  [2][3];
	tpc_pkg::vtx_t      pt     [2];

	tpc_pkg::side_t  side_d [tpc_pkg::EDGE_LAT];
	logic            vld_d  [tpc_pkg::EDGE_LAT];

	logic                out_valid_q, two_q, beat_q;
	tpc_pkg::tri_t       tri0_q, tri1_q;
	tpc_pkg::clip_kind_t kind_q;
	tpc_pkg::tri_t       t0, t1, first_c;
	tpc_pkg::side_t      tail;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_x_q     <= '0;
			coef_y_q     <= '0;
			coef_z_q     <= '0;
			coef_const_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				tpc_pkg::REG_COEF_X:     coef_x_q     <= cfg_wdata;
				tpc_pkg::REG_COEF_Y:     coef_y_q     <= cfg_wdata;
				tpc_pkg::REG_COEF_Z:     coef_z_q     <= cfg_wdata;
				tpc_pkg::REG_COEF_CONST: coef_const_q <= cfg_wdata;
				default:                 coef_x_q     <= coef_x_q;
			endcase
		end
	end

	// The pipeline moves as a whole whenever the output register can take
	// the item at its tail.
	assign en       = !out_valid_q || (m_tready && m_tlast);
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1 <= tpc_pkg::tri_t'(s_tdata);
			v_s2 <= v_s1;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_dist
		tpc_dist u_dist (
			.clk        (clk),
			.en         (en),
			.coef_x     (coef_x_q),
			.coef_y     (coef_y_q),
			.coef_z     (coef_z_q),
			.coef_const (coef_const_q),
			.vtx        (tpc_pkg::vtx_t'(s_tdata[i*3*tpc_pkg::CW +: 3*tpc_pkg::CW])),
			.plane_d    (vd[i])
		);
	end

	// One axis of the edge from vertex m (distance not negative) toward t.
	function automatic tpc_pkg::edge_job_t make_job(
		input tpc_pkg::coord_t               cm,
		input tpc_pkg::coord_t               ct,
		input logic signed [tpc_pkg::DW-1:0] dm,
		input logic signed [tpc_pkg::DW-1:0] dt
	);
		tpc_pkg::edge_job_t         j;
		logic signed [tpc_pkg::MAGW-1:0] delta;
		delta = tpc_pkg::MAGW'($signed(ct)) - tpc_pkg::MAGW'($signed(cm));
		j.sub = delta[tpc_pkg::MAGW-1];
		j.vm  = cm;
		j.mag = j.sub ? tpc_pkg::MAGW'(-delta) : tpc_pkg::MAGW'(delta);
		j.dm  = dm[tpc_pkg::DMW-1:0];
		j.den = tpc_pkg::DENW'(tpc_pkg::DENW'(dm) - tpc_pkg::DENW'(dt));
		return j;
	endfunction

	// Classification: first positive vertex, first negative vertex, and the
	// remaining one. Edge job A moves the third vertex toward the negative one
	// for a single cut, or the positive vertex toward the third for a split;
	// edge job B always moves the positive vertex toward the negative one.
	always_comb begin
		logic       has_pos, has_neg;
		logic [1:0] pos, neg, third, ma, ta;
		has_pos = (vd[0] > 0) || (vd[1] > 0) || (vd[2] > 0);
		has_neg = (vd[0] < 0) || (vd[1] < 0) || (vd[2] < 0);
		pos = (vd[0] > 0) ? 2'd0 : (vd[1] > 0) ? 2'd1 : 2'd2;
		neg = (vd[0] < 0) ? 2'd0 : (vd[1] < 0) ? 2'd1 : 2'd2;
		third = (has_pos && has_neg) ? 2'd3 - pos - neg : 2'd0;
		if (!has_pos) begin
			side_c.kind = tpc_pkg::KIND_WHOLE;
		end else if (!has_neg) begin
			side_c.kind = tpc_pkg::KIND_DROP;
		end else if (vd[third] >= 0) begin
			side_c.kind = tpc_pkg::KIND_ONE;
		end else begin
			side_c.kind = tpc_pkg::KIND_TWO;
		end
		ma = (side_c.kind == tpc_pkg::KIND_ONE) ? third : pos;
		ta = (side_c.kind == tpc_pkg::KIND_ONE) ? neg : third;
		side_c.v     = v_s2;
		side_c.pos   = pos;
		side_c.third = third;
		for (int k = 0; k < 3; k++) begin
			job_c[0][k] = make_job(v_s2[ma][k], v_s2[ta][k], vd[ma], vd[ta]);
			job_c[1][k] = make_job(v_s2[pos][k], v_s2[neg][k], vd[pos], vd[neg]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_c;
			job_s3  <= job_c;
		end
	end

	for (genvar j = 0; j < 2; j++) begin : g_job
		for (genvar k = 0; k < 3; k++) begin : g_axis
			tpc_edge #(
				.COORD_WIDTH (COORD_WIDTH)
			) u_edge (
				.clk (clk),
				.en  (en),
				.job (job_s3[j][k]),
				.res (pt[j][k])
			);
		end
	end

	// Side information rides alongside the edge lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tpc_pkg::EDGE_LAT; i++) begin
				vld_d[i] <= 1'b0;
			end
		end else if (en) begin
			vld_d[0] <= vld_s3;
			for (int i = 1; i < tpc_pkg::EDGE_LAT; i++) begin
				vld_d[i] <= vld_d[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_s3;
			for (int i = 1; i < tpc_pkg::EDGE_LAT; i++) begin
				side_d[i] <= side_d[i-1];
			end
		end
	end

	// Result triangles: t0 is the first half of a split, t1 is the single
	// clipped triangle and also the second half of a split.
	always_comb begin
		tail = side_d[tpc_pkg::EDGE_LAT-1];
		t0 = tail.v;
		t0[tail.pos] = pt[0];
		t1 = tail.v;
		t1[tail.third] = pt[0];
		t1[tail.pos] = pt[1];
		unique case (tail.kind)
			tpc_pkg::KIND_WHOLE: first_c = tail.v;
			tpc_pkg::KIND_ONE:   first_c = t1;
			tpc_pkg::KIND_TWO:   first_c = t0;
			tpc_pkg::KIND_DROP:  first_c = tail.v;
			default:             first_c = tail.v;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			two_q       <= 1'b0;
			beat_q      <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_d[tpc_pkg::EDGE_LAT-1] && (tail.kind != tpc_pkg::KIND_DROP);
			two_q       <= (tail.kind == tpc_pkg::KIND_TWO);
			beat_q      <= 1'b0;
		end else if (m_tready) begin
			beat_q      <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tri0_q <= first_c;
			tri1_q <= t1;
			kind_q <= tail.kind;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = beat_q ? tri1_q : tri0_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = !two_q || beat_q;

	// A beat that is not the last of its input belongs to a split triangle.
	a_split_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser == tpc_pkg::KIND_TWO)
		else $error("non-final beat outside a split");

	// After a split's first beat the second beat is still presented.
	a_split_second: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |=> m_tvalid)
		else $error("second beat of a split lost");

	// A whole triangle always leaves as a single final beat.
	a_whole_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == tpc_pkg::KIND_WHOLE |-> m_tlast)
		else $error("whole triangle not marked last");

	// The input side only moves when the output side is free.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

endmodule

FILE: verif/tpc_checker.sv
// Checker for the triangle plane clipper: predicts result beats and compares them.
`timescale 1ns / 100ps

module tpc_checker
	import tpc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_addr,
	input  logic [CW-1:0]       cfg_wdata,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [TRI_BITS-1:0] s_tdata,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [TRI_BITS-1:0] m_tdata,
	input  logic [1:0]          m_tuser,
	input  logic                m_tlast,
	output int                  fails,
	output int                  pending,
	output int                  n_results
);

	typedef struct {
		tri_t       v;
		clip_kind_t kind;
		logic       last;
	} clip_beat_t;

	coord_t     cx, cy, cz, cc;
	clip_beat_t want_q[$];

	function automatic longint plane_dist(vtx_t p);
		return ((longint'(cx) * longint'(p[0])) >>> 16)
		     + ((longint'(cy) * longint'(p[1])) >>> 16)
		     + ((longint'(cz) * longint'(p[2])) >>> 16) + longint'(cc);
	endfunction

	// Point where the edge from m (distance dm >= 0) toward t (dt < 0) meets the plane.
	function automatic vtx_t cut_edge(vtx_t m, vtx_t t, longint dm, longint dt);
		logic [127:0] num, den, quo;
		longint       delta, mag, res;
		vtx_t         r;
		den = 128'(dm - dt);
		for (int k = 0; k < 3; k++) begin
			delta = longint'(t[k]) - longint'(m[k]);
			mag   = (delta < 0) ? -delta : delta;
			num   = 128'(mag) * 128'(dm);
			quo   = num / den;
			res   = (delta < 0) ? longint'(m[k]) - signed'(quo[63:0])
			                    : longint'(m[k]) + signed'(quo[63:0]);
			if (res > 64'sd2147483647)
				res = 64'sd2147483647;
			else if (res < -64'sd2147483648)
				res = -64'sd2147483648;
			r[k] = res[CW-1:0];
		end
		return r;
	endfunction

	function automatic void clip_triangle(tri_t v);
		longint     d [3];
		int         pos, neg, third;
		tri_t       w;
		clip_beat_t b;
		for (int i = 0; i < 3; i++)
			d[i] = plane_dist(v[i]);
		pos = (d[0] > 0) ? 0 : (d[1] > 0) ? 1 : (d[2] > 0) ? 2 : 3;
		neg = (d[0] < 0) ? 0 : (d[1] < 0) ? 1 : (d[2] < 0) ? 2 : 3;
		if (pos == 3) begin
			b.v = v; b.kind = KIND_WHOLE; b.last = 1'b1;
			want_q.insert(want_q.size(), b);
		end else if (neg != 3) begin
			third = 3 - pos - neg;
			w = v;
			if (d[third] >= 0) begin
				w[third] = cut_edge(v[third], v[neg], d[third], d[neg]);
				w[pos]   = cut_edge(v[pos], v[neg], d[pos], d[neg]);
				b.v = w; b.kind = KIND_ONE; b.last = 1'b1;
				want_q.insert(want_q.size(), b);
			end else begin
				// Quadrilateral: two triangles sharing the cut toward third.
				w[pos] = cut_edge(v[pos], v[third], d[pos], d[third]);
				b.v = w; b.kind = KIND_TWO; b.last = 1'b0;
				want_q.insert(want_q.size(), b);
				w[third] = w[pos];
				w[pos]   = cut_edge(v[pos], v[neg], d[pos], d[neg]);
				b.v = w; b.last = 1'b1;
				want_q.insert(want_q.size(), b);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx <= '0; cy <= '0; cz <= '0; cc <= '0;
			fails <= 0;
			n_results <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_COEF_X:     cx <= cfg_wdata;
					REG_COEF_Y:     cy <= cfg_wdata;
					REG_COEF_Z:     cz <= cfg_wdata;
					REG_COEF_CONST: cc <= cfg_wdata;
				endcase
			end
			if (m_tvalid && m_tready) begin
				n_results <= n_results + 1;
				if (want_q.size() == 0) begin
					if (fails < 10)
						$display("%0t: result beat with nothing expected: %h", $time, m_tdata);
					fails <= fails + 1;
				end else begin
					clip_beat_t b;
					tri_t       got;
					bit         bad;
					b   = want_q.pop_front();
					got = m_tdata;
					bad = (m_tuser != b.kind) || (m_tlast != b.last);
					for (int i = 0; i < 3; i++)
						for (int j = 0; j < 3; j++)
							if (got[i][j] !== b.v[i][j])
								bad = 1;
					if (bad) begin
						if (fails < 10) begin
							$display("%0t: mismatch, case %0d/%0d last %0d/%0d (exp/act)",
							         $time, b.kind, m_tuser, b.last, m_tlast);
							for (int i = 0; i < 3; i++)
								$display("  vertex %0d exp %h %h %h act %h %h %h", i,
								         b.v[i][0], b.v[i][1], b.v[i][2],
								         got[i][0], got[i][1], got[i][2]);
						end
						fails <= fails + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				clip_triangle(s_tdata);
		end
	end

	assign pending = want_q.size();

endmodule

FILE: verif/tb_triangle_plane_clipper.sv
// Testbench top for the triangle plane clipper: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module tb_triangle_plane_clipper;
	import tpc_pkg::*;

	// Cycles a dropped triangle may still be in flight after the last result.
	localparam int SETTLE      = EDGE_LAT + 12;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 500;
	localparam int PHASE_ITEMS = 205;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [1:0]          cfg_addr = '0;
	logic [CW-1:0]       cfg_wdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [TRI_BITS-1:0] s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TRI_BITS-1:0] m_tdata;
	logic [1:0]          m_tuser;
	logic                m_tlast;

	int fails, pending, n_results;
	int n_sent = 0;
	int quiet  = 0;

	always #4 clk = ~clk;

	triangle_plane_clipper uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	tpc_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.fails(fails), .pending(pending), .n_results(n_results)
	);

	// Inside this window of beats the receiver never stalls and the sender inserts no random gaps.
	function automatic bit steady_window();
		return n_sent >= 700 && n_sent < 900;
	endfunction

	// The receiver stalls at random and, once, holds off for a long stretch
	// while the sender keeps pushing, so the pipeline fills and s_tready drops.
	initial begin
		int  hold;
		bit  held;
		hold = 0;
		held = 0;
		forever begin
			@(posedge clk);
			if (!held && n_sent >= 300) begin
				held = 1;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (steady_window())
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 99) >= 15);
		end
	end

	// Watchdog: a run of cycles with no beat on either side means the block hung.
	initial begin
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("timeout: %0d cycles without a beat, %0d results pending",
				         quiet, pending);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// All four plane registers, then the write enable drops once.
	task automatic write_plane(coord_t px, coord_t py, coord_t pz, coord_t pc);
		coord_t vals [4];
		vals = '{px, py, pz, pc};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= i[1:0];
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering, then wait until every expected result has arrived and
	// the pipeline has emptied.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Offer one triangle and hold it until the block takes the beat.
	task automatic send_tri(tri_t t);
		if (!steady_window() && $urandom_range(0, 99) < 15) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= t;
		do
			@(posedge clk);
		while (!(s_tvalid && s_tready));
		n_sent++;
	endtask

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom());
			1: return coord_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
			default: begin
				case ($urandom_range(0, 4))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return '0;
					3: return coord_t'(int'($urandom_range(0, 8)) - 4);
					default: return coord_t'($urandom());
				endcase
			end
		endcase
	endfunction

	function automatic tri_t rand_tri();
		tri_t t;
		int   r, mode;
		r    = $urandom_range(0, 99);
		mode = (r < 50) ? 1 : (r < 85) ? 0 : 2;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				t[i][j] = rand_coord(mode);
		return t;
	endfunction

	// Triangle whose x coordinates set the distance signs under the plane d = x.
	function automatic tri_t x_tri(coord_t ax, coord_t bx, coord_t cxv);
		tri_t t;
		t = rand_tri();
		t[0][0] = ax;
		t[1][0] = bx;
		t[2][0] = cxv;
		return t;
	endfunction

	initial begin
		tri_t   t;
		coord_t one, big, low;
		one = 32'sh00010000;
		big = 32'sh7fffffff;
		low = 32'sh80000000;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset plane: every distance is zero, so all triangles stay whole.
		t = '0;
		send_tri(t);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				t[i][j] = big;
		send_tri(t);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				t[i][j] = low;
		send_tri(t);
		drain();

		// Plane d = x: walk through sign patterns covering every clip case, and the corner values.
		write_plane(one, '0, '0, '0);
		send_tri(x_tri(-one, -one, -one));      // all inside
		send_tri(x_tri(one, one, one));         // all outside, dropped
		send_tri(x_tri(one, one, '0));          // outside touching the plane
		send_tri(x_tri('0, '0, '0));            // lying in the plane
		send_tri(x_tri(-one, '0, '0));          // inside with an edge on the plane
		send_tri(x_tri(one, -one, -one));       // one outside, split in two
		send_tri(x_tri(-one, one, -one));
		send_tri(x_tri(-one, -one, one));
		send_tri(x_tri(one, one, -one));        // one inside, clipped
		send_tri(x_tri(-one, one, one));
		send_tri(x_tri(one, '0, -one));         // cut through a vertex on the plane
		send_tri(x_tri(big, low, low));
		send_tri(x_tri(big, big, low));
		send_tri(x_tri(low, big, '0));
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_plane(one, '0, '0, '0);
				1: write_plane(big, low, big, low);
				2: write_plane(low, low, low, big);
				3: write_plane('0, '0, '0, '0);
				4: write_plane('0, -one, one, coord_t'(int'($urandom_range(0, 1 << 18))));
				default: write_plane(coord_t'($urandom()), coord_t'($urandom()),
				                     coord_t'($urandom()), coord_t'($urandom()));
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++)
				send_tri(rand_tri());
			s_tvalid <= 1'b0;
			@(posedge clk);
			drain();
		end

		$display("sent %0d triangles over ten plane settings, checked %0d result beats",
		         n_sent, n_results);
		if (fails == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: triangle_plane_clipper.f
hw/rtl/tpc_pkg.sv
hw/rtl/tpc_dist.sv
hw/rtl/tpc_edge.sv
hw/rtl/triangle_plane_clipper.sv
verif/tpc_checker.sv
verif/tb_triangle_plane_clipper.sv
